[rtl/tesa_pkg.sv]
package tesa_pkg;

  // Default storage sizes.
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_CLASSES_DEF = 8;

  // Field and register widths.
  localparam int SCORE_W    = 40;
  localparam int COUNT_W    = 16;
  localparam int CLS_CNT_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Register reset values.
  localparam logic [3:0]  CLASSES_RST = 4'd1;
  localparam logic [15:0] TREES_RST   = 16'd1;
  localparam logic [10:0] SAMPLES_RST = 11'd1024;

  // Saturation limits of the score accumulator.
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TASK_MODE       = 2'd0,
    REG_CLASSES_IN_USE  = 2'd1,
    REG_TREES_PER_CLASS = 2'd2,
    REG_SAMPLES_IN_USE  = 2'd3
  } cfg_reg_t;

  // One partial result request.
  typedef struct packed {
    logic [11:0]        sample_id;
    logic [2:0]         class_id;
    logic signed [31:0] partial_score;
    logic [7:0]         trees_covered;
  } request_t;

  // One finished prediction.
  typedef struct packed {
    logic [9:0]                done_sample;
    logic [2:0]                predicted_class;
    logic signed [SCORE_W-1:0] final_score;
  } result_t;

  // One entry of the accumulator store.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [COUNT_W-1:0]        count;
  } entry_t;

  // Write controls of the stores.
  typedef struct packed {
    logic wr_en;
    logic done_wr_en;
    logic done_wr_val;
  } store_ctl_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_ACC = 1'b0,
    ALU_CMP = 1'b1
  } alu_op_t;

  // Outputs of the shared arithmetic unit.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      gt;
    logic [COUNT_W-1:0]        count;
    logic                      below;
  } alu_res_t;

endpackage

[rtl/tesa_alu.sv]
module tesa_alu (
  input  tesa_pkg::alu_op_t                  op,
  input  logic signed [tesa_pkg::SCORE_W-1:0] a_score,
  input  logic signed [tesa_pkg::SCORE_W-1:0] b_score,
  input  logic [tesa_pkg::COUNT_W-1:0]        a_count,
  input  logic [7:0]                          trees,
  input  logic [tesa_pkg::COUNT_W-1:0]        target,
  output tesa_pkg::alu_res_t                  res
);
  import tesa_pkg::*;

  logic [SCORE_W:0]   a_ext;
  logic [SCORE_W:0]   b_ext;
  logic [SCORE_W:0]   sum;
  logic [COUNT_W:0]   cnt_sum;

  // One adder serves both the accumulate and the compare (as a subtract).
  assign a_ext = {a_score[SCORE_W-1], a_score};
  assign b_ext = (op == ALU_CMP) ? ~{b_score[SCORE_W-1], b_score}
                                 : {b_score[SCORE_W-1], b_score};
  assign sum   = a_ext + b_ext + {{SCORE_W{1'b0}}, (op == ALU_CMP)};

  // Tree count sum, one bit wider to catch the overflow.
  assign cnt_sum = {1'b0, a_count} + {{(COUNT_W-7){1'b0}}, trees};

  // Saturate the sum to the accumulator range; flag a strictly greater score.
  // The tree count saturates as well, and the completion compare runs beside it.
  always_comb begin
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      res.score = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      res.score = sum[SCORE_W-1:0];
    end
    res.gt    = !sum[SCORE_W] && (sum != '0);
    res.count = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
    res.below = a_count < target;
  end

endmodule

[rtl/tesa_store.sv]
module tesa_store #(
  parameter int MAX_SAMPLES = tesa_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CLASSES = tesa_pkg::MAX_CLASSES_DEF,
  parameter int AW          = 1,
  parameter int SW          = 1
) (
  input  logic                 clk,
  input  tesa_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]        wr_addr,
  input  tesa_pkg::entry_t     wr_data,
  input  logic [AW-1:0]        rd_addr,
  output tesa_pkg::entry_t     rd_data,
  input  logic [SW-1:0]        done_addr,
  output logic                 done_rdata
);
  import tesa_pkg::*;

  localparam int DEPTH = MAX_SAMPLES * MAX_CLASSES;

  entry_t acc_mem  [DEPTH];
  logic   done_mem [MAX_SAMPLES];

  // Score and tree count store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    rd_data <= acc_mem[rd_addr];
  end

  // Per-sample done flags, read and written at one address.
  always_ff @(posedge clk) begin
    if (ctl.done_wr_en) begin
      done_mem[done_addr] <= ctl.done_wr_val;
    end
    done_rdata <= done_mem[done_addr];
  end

endmodule

[rtl/tree_ensemble_score_aggregator_unit.sv]
// Collects partial tree-ensemble scores per sample and class and issues one
// prediction per sample once every class in use has seen trees_per_class
// trees. A request is taken when start is high and busy is low. After reset
// the block sweeps its stores to zero, one entry a cycle, covering all
// MAX_SAMPLES*MAX_CLASSES entries (8192 by default) with busy high. A request
// whose sample or class is out of range is dropped in its accept cycle. Any
// other request holds busy through one read-modify-write of the store when
// its sample has already been predicted; otherwise busy also stays high for
// one store read per class in use (one class in regression) through the
// shared add/compare unit, followed by a drain state and a finish state. A
// prediction appears on result for exactly one cycle with valid high, the
// first cycle in which busy is low again; the receiver cannot stall it and
// must take it then.
module tree_ensemble_score_aggregator_unit #(
  parameter int MAX_SAMPLES = tesa_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_CLASSES = tesa_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  tesa_pkg::request_t                 request,
  output logic                               valid,
  output tesa_pkg::result_t                  result,
  input  logic                               cfg_write,
  input  tesa_pkg::cfg_reg_t                 cfg_index,
  input  logic [tesa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tesa_pkg::*;

  localparam int DEPTH = MAX_SAMPLES * MAX_CLASSES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_ACC    = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic        task_mode;
  logic [3:0]  classes_in_use;
  logic [15:0] trees_per_class;
  logic [10:0] samples_in_use;

  // Sequencer registers.
  logic [AW-1:0]        clr, clr_next;
  logic [CLS_CNT_W-1:0] c, c_next;
  logic                 walk_vld;
  logic [CLS_CNT_W-1:0] walk_cls;
  logic                 complete;
  logic signed [SCORE_W-1:0] best;
  logic [CLS_CNT_W-1:0] pred;

  // Latched request.
  request_t      req_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] idx_q;

  // Store and unit connections.
  store_ctl_t                ctl;
  logic [AW-1:0]             wr_addr;
  entry_t                    wr_data;
  logic [AW-1:0]             rd_addr;
  entry_t                    rd_data;
  logic [SW-1:0]             done_addr;
  logic                      done_rdata;
  alu_op_t                   alu_op;
  logic signed [SCORE_W-1:0] alu_b;
  alu_res_t                  alu_res;

  logic [CLS_CNT_W-1:0] ncls;
  logic                 in_range;
  logic [2:0]           cls_eff;
  logic [AW-1:0]        base_calc;

  // Effective class count: one in regression, otherwise clamped to 1..MAX_CLASSES.
  always_comb begin
    if (task_mode) begin
      ncls = CLS_CNT_W'(1);
    end else if (classes_in_use == '0) begin
      ncls = CLS_CNT_W'(1);
    end else if (int'(classes_in_use) > MAX_CLASSES) begin
      ncls = CLS_CNT_W'(MAX_CLASSES);
    end else begin
      ncls = classes_in_use;
    end
  end

  // Range checks and store address of an incoming request.
  assign in_range  = (request.sample_id < {1'b0, samples_in_use}) &&
                     (int'(request.sample_id) < MAX_SAMPLES) &&
                     (task_mode || ({1'b0, request.class_id} < ncls));
  assign cls_eff   = task_mode ? 3'd0 : request.class_id;
  assign base_calc = AW'(int'(request.sample_id) * MAX_CLASSES);

  assign busy = (state != S_IDLE);

  // Sequencer and store control.
  always_comb begin
    state_next = state;
    clr_next   = clr;
    c_next     = c;
    ctl        = '0;
    wr_addr    = idx_q;
    wr_data    = '{score: alu_res.score, count: alu_res.count};
    rd_addr    = idx_q;
    done_addr  = SW'(req_q.sample_id);
    alu_op     = ALU_CMP;
    unique case (state)
      S_CLEAR: begin
        ctl.wr_en      = 1'b1;
        ctl.done_wr_en = (int'(clr) < MAX_SAMPLES);
        wr_addr        = clr;
        wr_data        = '0;
        done_addr      = SW'(clr);
        if (clr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_next = clr + 1'b1;
        end
      end
      S_IDLE: begin
        if (start && in_range) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        alu_op    = ALU_ACC;
        ctl.wr_en = 1'b1;
        c_next    = '0;
        state_next = done_rdata ? S_IDLE : S_WALK;
      end
      S_WALK: begin
        rd_addr = base_q + AW'(c);
        c_next  = c + 1'b1;
        if (c == ncls - 1'b1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.done_wr_en  = complete;
        ctl.done_wr_val = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The unit adds the partial score or compares against the running best.
  assign alu_b = (state == S_ACC) ?
                 {{(SCORE_W-32){req_q.partial_score[31]}}, req_q.partial_score} : best;

  tesa_alu u_alu (
    .op      (alu_op),
    .a_score (rd_data.score),
    .b_score (alu_b),
    .a_count (rd_data.count),
    .trees   (req_q.trees_covered),
    .target  (trees_per_class),
    .res     (alu_res)
  );

  tesa_store #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_CLASSES (MAX_CLASSES),
    .AW          (AW),
    .SW          (SW)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done_addr  (done_addr),
    .done_rdata (done_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      c        <= '0;
      walk_vld <= 1'b0;
      valid    <= 1'b0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      c        <= c_next;
      walk_vld <= (state == S_WALK);
      valid    <= (state == S_FINISH) && complete;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_mode       <= 1'b0;
      classes_in_use  <= CLASSES_RST;
      trees_per_class <= TREES_RST;
      samples_in_use  <= SAMPLES_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TASK_MODE:       task_mode       <= cfg_data[0];
        REG_CLASSES_IN_USE:  classes_in_use  <= cfg_data[3:0];
        REG_TREES_PER_CLASS: trees_per_class <= cfg_data[15:0];
        REG_SAMPLES_IN_USE:  samples_in_use  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Request capture, class walk bookkeeping and the result register.
  always_ff @(posedge clk) begin
    walk_cls <= c;
    if (state == S_IDLE && start) begin
      req_q  <= request;
      base_q <= base_calc;
      idx_q  <= base_calc + AW'(cls_eff);
    end
    if (state == S_ACC) begin
      complete <= 1'b1;
    end
    if (walk_vld) begin
      if (alu_res.below) begin
        complete <= 1'b0;
      end
      if (walk_cls == '0 || alu_res.gt) begin
        best <= rd_data.score;
        pred <= walk_cls;
      end
    end
    if (state == S_FINISH) begin
      result.done_sample <= 10'(req_q.sample_id);
      result.final_score <= best;
      if (task_mode) begin
        result.predicted_class <= 3'd0;
      end else if (ncls == CLS_CNT_W'(1)) begin
        result.predicted_class <= {2'b00, ~best[SCORE_W-1]};
      end else begin
        result.predicted_class <= 3'(pred);
      end
    end
  end

endmodule
